// ===== src/e2q_pkg.sv =====
// types and constants for the euler-to-quaternion unit
// no dependencies
`default_nettype none
package e2q_pkg;
    localparam int MAX_STAGES = 24;
    localparam int ANG_W      = 15;
    localparam int QUAT_W     = 16;
    localparam int CW         = 34;   // cordic x, y: q2.30 plus headroom
    localparam int ZW         = 33;   // binary angle accumulator
    localparam int SCW        = 22;   // sin/cos q20 with sign
    localparam logic [29:0] RAD_TO_TURN = 30'd683565276;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ZW-1:0] TURN_HALF_PI = 33'sd1073741824;
    localparam logic signed [ZW-1:0] TURN_PI = 33'sd2147483648;

    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic signed [ZW-1:0] t;
        begin
            unique case (i)
                0: t = 33'sd536870912;   1: t = 33'sd316933406;
                2: t = 33'sd167458907;   3: t = 33'sd85004756;
                4: t = 33'sd42667331;    5: t = 33'sd21354465;
                6: t = 33'sd10679838;    7: t = 33'sd5340245;
                8: t = 33'sd2670163;     9: t = 33'sd1335087;
                10: t = 33'sd667544;     11: t = 33'sd333772;
                12: t = 33'sd166886;     13: t = 33'sd83443;
                14: t = 33'sd41722;      15: t = 33'sd20861;
                16: t = 33'sd10430;      17: t = 33'sd5215;
                18: t = 33'sd2608;       19: t = 33'sd1304;
                20: t = 33'sd652;        21: t = 33'sd326;
                22: t = 33'sd163;        23: t = 33'sd81;
                default: t = '0;
            endcase
            return t;
        end
    endfunction
endpackage
`default_nettype wire

// ===== src/e2q_sincos.sv =====
// pipelined half-angle sine/cosine: angle scaling, one cordic stage per register
// depends on e2q_pkg
`default_nettype none
module e2q_sincos #(
    parameter int STAGES = 16
) (
    input  wire  logic                         clk,
    input  wire  logic                         en,
    input  wire  logic [e2q_pkg::ANG_W-1:0]    angle,
    output logic signed [e2q_pkg::SCW-1:0]     sin_q20,
    output logic signed [e2q_pkg::SCW-1:0]     cos_q20
);
    import e2q_pkg::*;
    localparam int NS = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

    // stage a: magnitude times scale
    logic [14:0] mag;
    logic [44:0] prod_reg;
    logic        neg_a_reg;
    assign mag = angle[14] ? 15'(-angle) : angle;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= mag * RAD_TO_TURN;
            neg_a_reg <= angle[14];
        end
    end

    // stage b: round, fold beyond quarter turn
    logic signed [ZW-1:0] th;
    logic signed [ZW-1:0] z0_reg;
    logic                 flip0_reg, neg0_reg;
    assign th = ZW'((prod_reg + 45'd4096) >> 13);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg    <= (th > TURN_HALF_PI) ? TURN_PI - th : th;
            flip0_reg <= th > TURN_HALF_PI;
            neg0_reg  <= neg_a_reg;
        end
    end

    logic signed [CW-1:0] x_reg [NS+1];
    logic signed [CW-1:0] y_reg [NS+1];
    logic signed [ZW-1:0] z_reg [NS+1];
    logic                 flip_reg [NS+1];
    logic                 neg_reg [NS+1];
    assign x_reg[0] = CORDIC_GAIN;
    assign y_reg[0] = '0;
    assign z_reg[0] = z0_reg;
    assign flip_reg[0] = flip0_reg;
    assign neg_reg[0] = neg0_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_turn(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_turn(i);
                end
                flip_reg[i+1] <= flip_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
            end
        end
    end

    // final: round q30 to q20, apply sign fixes
    logic signed [CW-1:0] s_r, c_r;
    logic signed [SCW-1:0] s_n, c_n;
    assign s_r = (y_reg[NS] + CW'(512)) >>> 10;
    assign c_r = (x_reg[NS] + CW'(512)) >>> 10;
    assign s_n = SCW'(s_r);
    assign c_n = SCW'(c_r);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_q20 <= neg_reg[NS] ? -s_n : s_n;
            cos_q20 <= flip_reg[NS] ? -c_n : c_n;
        end
    end
endmodule
`default_nettype wire

// ===== src/euler_to_quaternion_unit.sv =====
// euler angles (zyx) to unit quaternion, top level with product pipeline
// depends on e2q_pkg and e2q_sincos
`default_nettype none
// CORDIC_STAGES is clamped to at most 24; a transaction passes the sincos lanes, product stages and output register
// throughput: one transaction per cycle; the whole pipe advances when the
// output register is empty or being taken, so a stall freezes every stage
// reset: valid bits cleared by rst_n, payload registers are not reset
module euler_to_quaternion_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  logic [47:0] s_axis_tdata,  // roll_angle, pitch_angle, yaw_angle, 3'b0
    output logic              m_axis_tvalid,
    input  wire  logic        m_axis_tready,
    output logic [63:0]       m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);
    import e2q_pkg::*;
    localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    // one valid bit per register from the sincos input stage through product stage 5
    localparam int LAT = NS + 8;

    logic en;
    logic [LAT-1:0] vld_reg;
    // pipe moves unless the output holds a transaction that is not being taken
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
            m_axis_tvalid <= vld_reg[LAT-1];
        end
    end

    // three cordic lanes in parallel
    logic signed [SCW-1:0] sr, cr, sp, cp, sy, cy;
    e2q_sincos #(.STAGES(CORDIC_STAGES)) u_roll (.clk(clk), .en(en),
        .angle(s_axis_tdata[14:0]),  .sin_q20(sr), .cos_q20(cr));
    e2q_sincos #(.STAGES(CORDIC_STAGES)) u_pitch (.clk(clk), .en(en),
        .angle(s_axis_tdata[29:15]), .sin_q20(sp), .cos_q20(cp));
    e2q_sincos #(.STAGES(CORDIC_STAGES)) u_yaw (.clk(clk), .en(en),
        .angle(s_axis_tdata[44:30]), .sin_q20(sy), .cos_q20(cy));

    // products stage 1: roll/pitch pairs (q40)
    logic signed [43:0] cc_reg, ss_reg, sc_reg, cs_reg;
    logic signed [SCW-1:0] sy1_reg, cy1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg <= 44'(cr * cp);
            ss_reg <= 44'(sr * sp);
            sc_reg <= 44'(sr * cp);
            cs_reg <= 44'(cr * sp);
            sy1_reg <= sy;
            cy1_reg <= cy;
        end
    end

    // operand pairs for the eight triple products
    logic signed [43:0]    pa [8];
    logic signed [SCW-1:0] pb [8];
    assign pa[0] = cc_reg;  assign pb[0] = cy1_reg;
    assign pa[1] = ss_reg;  assign pb[1] = sy1_reg;
    assign pa[2] = sc_reg;  assign pb[2] = cy1_reg;
    assign pa[3] = cs_reg;  assign pb[3] = sy1_reg;
    assign pa[4] = cs_reg;  assign pb[4] = cy1_reg;
    assign pa[5] = sc_reg;  assign pb[5] = sy1_reg;
    assign pa[6] = cc_reg;  assign pb[6] = sy1_reg;
    assign pa[7] = ss_reg;  assign pb[7] = cy1_reg;

    // stage 2: yaw term times upper and lower halves of the pair product
    // stage 3: recombine halves into the q60 triple product
    logic signed [43:0] hi_reg [8];
    logic signed [44:0] lo_reg [8];
    logic signed [65:0] p_reg [8];
    for (genvar j = 0; j < 8; j++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[j] <= 45'($signed({1'b0, pa[j][21:0]}) * pb[j]);
                hi_reg[j] <= 44'($signed(pa[j][43:22]) * pb[j]);
                p_reg[j]  <= (66'(hi_reg[j]) <<< 22) + 66'(lo_reg[j]);
            end
        end
    end

    // stage 4: sums with rounding bias
    logic signed [66:0] sum_reg [4];
    localparam logic signed [66:0] HALF = 67'sd1 <<< 45;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0] <= 67'(p_reg[0]) + 67'(p_reg[1]) + HALF;
            sum_reg[1] <= 67'(p_reg[2]) - 67'(p_reg[3]) + HALF;
            sum_reg[2] <= 67'(p_reg[4]) + 67'(p_reg[5]) + HALF;
            sum_reg[3] <= 67'(p_reg[6]) - 67'(p_reg[7]) + HALF;
        end
    end

    // stage 5: shift and saturate
    logic [QUAT_W-1:0] q_reg [4];
    for (genvar k = 0; k < 4; k++)
    begin : g_sat
        logic signed [20:0] v;
        assign v = 21'(sum_reg[k] >>> 46);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v > 21'sd16384)
                    q_reg[k] <= 16'sd16384;
                else if (v < -21'sd16384)
                    q_reg[k] <= -16'sd16384;
                else
                    q_reg[k] <= v[15:0];
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
            m_axis_tdata <= {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
    end
endmodule
`default_nettype wire
